// ===== rtl/decimal_int_line_parser_macros.svh =====
// Assertion macros used by the top level of the decimal line parser.
`ifndef DECIMAL_INT_LINE_PARSER_MACROS_SVH
`define DECIMAL_INT_LINE_PARSER_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define DILP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define DILP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DILP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dilp_pkg.sv =====
// Types and constants of the decimal line parser.
package dilp_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_NUMERIC = 2'd1;
  localparam logic [1:0] ST_OVERFLOW    = 2'd2;
  localparam logic [1:0] ST_RANGE       = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 1'd1;

  localparam logic signed [31:0] LOWER_BOUND_RST = 32'sh8000_0000;
  localparam logic signed [31:0] UPPER_BOUND_RST = 32'sh7FFF_FFFF;

  // Position within a line.
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL
  } line_phase_e;

  typedef struct packed {
    logic [7:0] char_code;
  } char_item_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic [1:0]         parse_status;
  } result_item_t;

  // Input register contents handed to the parse core.
  typedef struct packed {
    logic       valid;
    char_item_t item;
  } stage_t;

endpackage

// ===== rtl/dilp_char_if.sv =====
// Valid/ready channel that carries one input character per item.
interface dilp_char_if;
  logic                 valid;
  logic                 ready;
  dilp_pkg::char_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dilp_result_if.sv =====
// Valid/ready channel that carries one parse result per item.
interface dilp_result_if;
  logic                   valid;
  logic                   ready;
  dilp_pkg::result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dilp_in_stage.sv =====
// Input register stage of the decimal line parser.
module dilp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  dilp_char_if.sink        char_i,
  input  logic             take_i,
  output dilp_pkg::stage_t stage_o
);
  import dilp_pkg::*;

  logic       valid_q, valid_d;
  char_item_t item_q;
  logic       load;

  // The register frees up whenever the core takes the held item.
  assign char_i.ready = !valid_q || take_i;
  assign load = char_i.valid && char_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= char_i.data;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== rtl/dilp_parse_core.sv =====
// Line state, digit accumulation and result register of the decimal line parser.
module dilp_parse_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dilp_pkg::stage_t   stage_i,
  output logic               take_o,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  dilp_result_if.source      result_o
);
  import dilp_pkg::*;

  localparam int unsigned MAG_W = VALUE_BITS - 1;
  localparam int unsigned PROD_W = MAG_W + 4;
  localparam int unsigned CMP_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  line_phase_e phase_q, phase_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic neg_q, neg_d;
  logic bad_q, bad_d;
  logic ovf_q, ovf_d;

  logic         out_valid_q, out_valid_d;
  result_item_t out_item_q;
  result_item_t res_item;
  logic         res_load;

  logic [7:0]        ch;
  logic              is_nl;
  logic              is_digit;
  logic [3:0]        digit;
  logic [PROD_W-1:0] prod;
  logic              digit_ovf;
  logic [MAG_W-1:0]  mag_add;
  logic              ovf_add;
  logic              out_free;

  logic signed [VALUE_BITS-1:0] val_s;
  logic signed [CMP_W-1:0]      val_ext;
  logic signed [CMP_W-1:0]      lo_ext;
  logic signed [CMP_W-1:0]      hi_ext;
  logic                         in_range;

  assign ch       = stage_i.item.char_code;
  assign is_nl    = (ch == CH_NL);
  assign is_digit = (ch inside {[CH_ZERO:CH_NINE]});
  assign digit    = 4'(ch - CH_ZERO);

  // Times ten plus the digit; the limit is all ones, so any carry into the
  // top four bits means the magnitude went past it.
  assign prod = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + PROD_W'(digit);
  assign digit_ovf = |prod[PROD_W-1:MAG_W];

  // Once overflow is seen the magnitude freezes.
  always_comb begin
    mag_add = mag_q;
    ovf_add = ovf_q;
    if (!ovf_q) begin
      if (digit_ovf) begin
        ovf_add = 1'b1;
      end else begin
        mag_add = prod[MAG_W-1:0];
      end
    end
  end

  // Signed value and range check against the configured bounds.
  assign val_s    = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign val_ext  = CMP_W'(val_s);
  assign lo_ext   = CMP_W'(lower_bound_i);
  assign hi_ext   = CMP_W'(upper_bound_i);
  assign in_range = (val_ext >= lo_ext) && (val_ext <= hi_ext);

  always_comb begin
    res_item.parsed_value = '0;
    if (bad_q) begin
      res_item.parse_status = ST_NOT_NUMERIC;
    end else if (ovf_q) begin
      res_item.parse_status = ST_OVERFLOW;
    end else begin
      res_item.parsed_value = 32'(val_ext);
      res_item.parse_status = in_range ? ST_OK : ST_RANGE;
    end
  end

  // A newline waits for room in the result register; other characters
  // always pass.
  assign out_free = !out_valid_q || result_o.ready;
  assign take_o   = stage_i.valid && (!is_nl || out_free);

  // Next line state.
  always_comb begin
    phase_d  = phase_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    bad_d    = bad_q;
    ovf_d    = ovf_q;
    res_load = 1'b0;
    if (take_o) begin
      if (is_nl) begin
        res_load = 1'b1;
        phase_d  = PH_LEAD;
        mag_d    = '0;
        neg_d    = 1'b0;
        bad_d    = 1'b0;
        ovf_d    = 1'b0;
      end else begin
        case (phase_q)
          PH_LEAD: begin
            if (ch == CH_SPACE) begin
              phase_d = PH_LEAD;
            end else if (ch == CH_PLUS || ch == CH_MINUS) begin
              neg_d   = (ch == CH_MINUS);
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              mag_d   = mag_add;
              ovf_d   = ovf_add;
              phase_d = PH_DIGITS;
            end else begin
              bad_d = 1'b1;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
              mag_d   = mag_add;
              ovf_d   = ovf_add;
              phase_d = PH_DIGITS;
            end else if (ch == CH_SPACE) begin
              phase_d = PH_TRAIL;
            end else begin
              bad_d = 1'b1;
            end
          end
          default: begin
            if (ch != CH_SPACE) begin
              bad_d = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Result handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      bad_q       <= bad_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_item_q <= res_item;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

endmodule

// ===== rtl/decimal_int_line_parser.sv =====
// A newline item passes through the input register and then the result register before its result shows.
// Throughput: one character item per cycle; only a newline waits, and only
// while the result register still holds a result nobody has taken.
// Reset (asynchronous, active low) clears the line state and both stages and
// restores the bounds to the full 32-bit signed range.
// Top level of the decimal line parser.
`include "decimal_int_line_parser_macros.svh"

module decimal_int_line_parser #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dilp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dilp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  dilp_char_if.sink                          char_i,
  dilp_result_if.source                      result_o
);
  import dilp_pkg::*;

  logic signed [31:0] lower_bound_q;
  logic signed [31:0] upper_bound_q;
  stage_t             stage;
  logic               take;

  // Bound registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_bound_q <= LOWER_BOUND_RST;
      upper_bound_q <= UPPER_BOUND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOWER_BOUND: lower_bound_q <= $signed(cfg_data_i);
        CFG_UPPER_BOUND: upper_bound_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  dilp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .take_i  (take),
    .stage_o (stage)
  );

  dilp_parse_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_parse_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .take_o        (take),
    .lower_bound_i (lower_bound_q),
    .upper_bound_i (upper_bound_q),
    .result_o      (result_o)
  );

  // Input only stalls while the input register holds an item.
  `DILP_ASSERT_IMP(a_stall_only_when_full, !char_i.ready, stage.valid, "input stalled while empty")
  // A new result always comes from a newline held in the input register.
  `DILP_ASSERT_IMP(a_result_from_newline, $rose(result_o.valid), $past(stage.valid && (stage.item.char_code == CH_NL)), "result without newline")
  // Error results carry a zero value.
  `DILP_ASSERT_IMP(a_error_value_zero, result_o.valid && (result_o.data.parse_status == ST_NOT_NUMERIC || result_o.data.parse_status == ST_OVERFLOW), result_o.data.parsed_value == 32'sd0, "error result with nonzero value")
  // An accepted value lies within the bounds.
  `DILP_ASSERT_IMP(a_ok_in_bounds, result_o.valid && (result_o.data.parse_status == ST_OK), (result_o.data.parsed_value >= lower_bound_q) && (result_o.data.parsed_value <= upper_bound_q), "ok result outside bounds")

endmodule
